[design/obbfc_pkg.sv]
// shared constants, types and codes for the oriented box frustum cull core
// no dependencies
package obbfc_pkg;

   localparam int DEF_COMPONENT_WIDTH = 16;
   localparam int FIELD_WIDTH = 48;
   localparam int PLANE_WIDTH = 64;
   localparam int NUM_PLANES = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int NUM_STAGES = 5;
   localparam int CLASS_WIDTH = 2;

   typedef enum logic [CLASS_WIDTH-1:0] {
      CLASS_OUTSIDE      = 2'd0,
      CLASS_INSIDE       = 2'd1,
      CLASS_INTERSECTING = 2'd2
   } class_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctrl_type;

endpackage

[design/obbfc_pipe_ctrl.sv]
// valid bits and per-stage advance enables for the cull pipeline
// depends on obbfc_pkg
module obbfc_pipe_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output obbfc_pkg::pipe_ctrl_type   ctrl
);
   import obbfc_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.en = en;
   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

endmodule

[design/obbfc_plane_lane.sv]
// one plane's datapath: products, dot and extent sums, per-plane flags
// four register stages; depends on obbfc_pkg
module obbfc_plane_lane #(
   parameter int COMPONENT_WIDTH = obbfc_pkg::DEF_COMPONENT_WIDTH
) (
   input  logic                                clock,
   input  obbfc_pkg::pipe_ctrl_type            ctrl,
   input  logic [obbfc_pkg::PLANE_WIDTH-1:0]   plane,
   input  logic [obbfc_pkg::FIELD_WIDTH-1:0]   box_center,
   input  logic [obbfc_pkg::FIELD_WIDTH-1:0]   box_axis_a,
   input  logic [obbfc_pkg::FIELD_WIDTH-1:0]   box_axis_b,
   input  logic [obbfc_pkg::FIELD_WIDTH-1:0]   box_axis_c,
   input  logic [obbfc_pkg::FIELD_WIDTH-1:0]   box_half_sizes,
   output logic                                out_flag,
   output logic                                in_flag
);
   import obbfc_pkg::*;

   localparam int W = COMPONENT_WIDTH;
   localparam int PADW = 4 * W + PLANE_WIDTH;
   localparam int PW = 2 * W;
   localparam int DW = 2 * W + 1;
   localparam int MW = 2 * W;
   localparam int QW = MW + 1 - (W - 2);
   localparam int SW = 2 * W + 2;
   localparam int HW = W + QW + 1;
   localparam int EW = HW + 2;
   localparam int CW = 2 * W + 8;
   localparam logic [MW:0] ROUND_ADD = (MW + 1)'((1 << (W - 2)) - 1);

   // components past the top of a word read as zero
   function automatic logic signed [W-1:0] comp(input logic [PLANE_WIDTH-1:0] word,
                                                input int idx);
      logic [PADW-1:0] pad;
      pad = {{(4 * W){1'b0}}, word};
      return $signed(pad[idx*W +: W]);
   endfunction

   logic [PLANE_WIDTH-1:0] axes [3];

   assign axes[0] = PLANE_WIDTH'(box_axis_a);
   assign axes[1] = PLANE_WIDTH'(box_axis_b);
   assign axes[2] = PLANE_WIDTH'(box_axis_c);

   // stage 1
   logic signed [PW-1:0] ax_prod_ff [3][3];
   logic signed [PW-1:0] ctr_prod_ff [3];
   logic signed [W-1:0]  offset_ff;
   logic signed [W-1:0]  half1_ff [3];

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               ax_prod_ff[i][j] <= comp(plane, j) * comp(axes[i], j);
            end
            ctr_prod_ff[i] <= comp(plane, i) * comp(PLANE_WIDTH'(box_center), i);
            half1_ff[i] <= comp(PLANE_WIDTH'(box_half_sizes), i);
         end
         offset_ff <= comp(plane, 3);
      end
   end

   // stage 2
   logic signed [DW-1:0] dot [3];
   logic [MW-1:0]        mag [3];
   logic [MW:0]          rnd [3];
   logic signed [SW-1:0] dist_in;
   logic [QW-1:0]        q_ff [3];
   logic signed [SW-1:0] dist2_ff;
   logic signed [W-1:0]  half2_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dot[i] = DW'(ax_prod_ff[i][0]) + DW'(ax_prod_ff[i][1]) + DW'(ax_prod_ff[i][2]);
         mag[i] = dot[i][DW-1] ? MW'(-dot[i]) : MW'(dot[i]);
         rnd[i] = (MW + 1)'(mag[i]) + ROUND_ADD;
      end
      dist_in = SW'(ctr_prod_ff[0]) + SW'(ctr_prod_ff[1]) + SW'(ctr_prod_ff[2])
              + (SW'(offset_ff) <<< (W - 2));
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[1]) begin
         for (int i = 0; i < 3; i++) begin
            q_ff[i] <= rnd[i][MW:W-2];
            half2_ff[i] <= half1_ff[i];
         end
         dist2_ff <= dist_in;
      end
   end

   // stage 3
   logic signed [HW-1:0] he_ff [3];
   logic signed [SW-1:0] dist3_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en[2]) begin
         for (int i = 0; i < 3; i++) begin
            he_ff[i] <= half2_ff[i] * $signed({1'b0, q_ff[i]});
         end
         dist3_ff <= dist2_ff;
      end
   end

   // stage 4
   logic signed [EW-1:0] extent;
   logic signed [CW-1:0] lo;
   logic signed [CW-1:0] hi;
   logic                 out_flag_ff;
   logic                 in_flag_ff;

   always_comb begin
      extent = EW'(he_ff[0]) + EW'(he_ff[1]) + EW'(he_ff[2]);
      lo = CW'(dist3_ff) - CW'(extent);
      hi = CW'(dist3_ff) + CW'(extent);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         out_flag_ff <= !lo[CW-1] && (lo != '0);
         in_flag_ff <= !hi[CW-1];
      end
   end

   assign out_flag = out_flag_ff;
   assign in_flag = in_flag_ff;

endmodule

[design/obb_frustum_cull_core.sv]
// top level of the oriented box frustum cull core: plane registers, six lanes,
// classification and output register; depends on obbfc_pkg, obbfc_pipe_ctrl,
// obbfc_plane_lane
//
//   channel | ports                         | handshake
//   req     | req_box_* (5 x 48 bit)        | req_valid / req_stall
//   rsp     | rsp_classification (2 bit)    | rsp_valid / rsp_stall
//   csr     | csr_index (3), csr_data (64)  | csr_valid / csr_ready
//
// one word enters per cycle while req_stall is low; each result passes through
// the five register stages (products, dots, extent products, flags, class)
// synchronous reset clears the valid bits and the six plane registers to zero
// a stalled output holds; earlier stages keep filling bubbles before req_stall rises
// csr_ready is always high; indexes 6 and 7 are dropped
module obb_frustum_cull_core #(
   parameter int COMPONENT_WIDTH = obbfc_pkg::DEF_COMPONENT_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [obbfc_pkg::FIELD_WIDTH-1:0]       req_box_center,
   input  logic [obbfc_pkg::FIELD_WIDTH-1:0]       req_box_axis_a,
   input  logic [obbfc_pkg::FIELD_WIDTH-1:0]       req_box_axis_b,
   input  logic [obbfc_pkg::FIELD_WIDTH-1:0]       req_box_axis_c,
   input  logic [obbfc_pkg::FIELD_WIDTH-1:0]       req_box_half_sizes,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [obbfc_pkg::CLASS_WIDTH-1:0]       rsp_classification,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [obbfc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [obbfc_pkg::PLANE_WIDTH-1:0]       csr_data
);
   import obbfc_pkg::*;

   logic [PLANE_WIDTH-1:0] plane_ff [NUM_PLANES];
   pipe_ctrl_type          ctrl;
   logic [NUM_PLANES-1:0]  out_flags;
   logic [NUM_PLANES-1:0]  in_flags;
   class_type              class_in;
   class_type              class_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            plane_ff[p] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            if (csr_index == CSR_INDEX_WIDTH'(p)) begin
               plane_ff[p] <= csr_data;
            end
         end
      end
   end

   obbfc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl)
   );

   for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
      obbfc_plane_lane #(
         .COMPONENT_WIDTH (COMPONENT_WIDTH)
      ) u_lane (
         .clock          (clock),
         .ctrl           (ctrl),
         .plane          (plane_ff[p]),
         .box_center     (req_box_center),
         .box_axis_a     (req_box_axis_a),
         .box_axis_b     (req_box_axis_b),
         .box_axis_c     (req_box_axis_c),
         .box_half_sizes (req_box_half_sizes),
         .out_flag       (out_flags[p]),
         .in_flag        (in_flags[p])
      );
   end

   always_comb begin
      if (|out_flags) begin
         class_in = CLASS_OUTSIDE;
      end else if (|in_flags) begin
         class_in = CLASS_INTERSECTING;
      end else begin
         class_in = CLASS_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[NUM_STAGES-1]) begin
         class_ff <= class_in;
      end
   end

   assign rsp_classification = class_ff;

endmodule

[verif/testbench.sv]
// self-checking testbench for obb_frustum_cull_core: directed and random boxes
// against a local fixed-point model of the six-plane cull test
// depends on obbfc_pkg and obb_frustum_cull_core
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import obbfc_pkg::*;

   localparam int CW = DEF_COMPONENT_WIDTH;
   localparam int POS_FRAC = CW / 2;
   localparam int AXIS_FRAC = CW - 2;
   localparam longint ONE_POS = longint'(1) << POS_FRAC;
   localparam longint ONE_AXIS = longint'(1) << AXIS_FRAC;
   localparam longint COMP_SPAN = longint'(1) << CW;
   localparam longint COMP_MAX = (longint'(1) << (CW - 1)) - 1;
   localparam longint COMP_MIN = -(longint'(1) << (CW - 1));
   localparam int DRAIN_CYCLES = 4 * NUM_STAGES;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 475;

   typedef struct {
      logic [FIELD_WIDTH-1:0] center;
      logic [FIELD_WIDTH-1:0] axis_a;
      logic [FIELD_WIDTH-1:0] axis_b;
      logic [FIELD_WIDTH-1:0] axis_c;
      logic [FIELD_WIDTH-1:0] halves;
   } box_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FIELD_WIDTH-1:0] req_box_center = '0;
   logic [FIELD_WIDTH-1:0] req_box_axis_a = '0;
   logic [FIELD_WIDTH-1:0] req_box_axis_b = '0;
   logic [FIELD_WIDTH-1:0] req_box_axis_c = '0;
   logic [FIELD_WIDTH-1:0] req_box_half_sizes = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CLASS_WIDTH-1:0] rsp_classification;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [PLANE_WIDTH-1:0] csr_data = '0;

   logic [PLANE_WIDTH-1:0] plane_regs [NUM_PLANES] = '{default: '0};
   class_type expected_class [$];
   int error_count = 0;
   int cycle_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   obb_frustum_cull_core #(.COMPONENT_WIDTH(CW)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_box_center(req_box_center),
      .req_box_axis_a(req_box_axis_a),
      .req_box_axis_b(req_box_axis_b),
      .req_box_axis_c(req_box_axis_c),
      .req_box_half_sizes(req_box_half_sizes),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_classification(rsp_classification),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   function automatic longint component(input logic [63:0] w, input int idx);
      logic [63:0] v;
      if (idx * CW >= 64) return 0;
      v = (w >> (idx * CW)) & ((64'd1 << CW) - 64'd1);
      if (v[CW-1]) return longint'(v) - COMP_SPAN;
      return longint'(v);
   endfunction

   function automatic longint dot3(input logic [63:0] a, input logic [63:0] b);
      return component(a, 0) * component(b, 0) + component(a, 1) * component(b, 1) +
             component(a, 2) * component(b, 2);
   endfunction

   function automatic class_type classify_box(input box_type b);
      logic [63:0] axes [3];
      longint extent, center_dist, d, mag, q;
      logic outside, touching;
      outside = 1'b0;
      touching = 1'b0;
      axes[0] = 64'(b.axis_a);
      axes[1] = 64'(b.axis_b);
      axes[2] = 64'(b.axis_c);
      for (int p = 0; p < NUM_PLANES; p++) begin
         extent = 0;
         for (int i = 0; i < 3; i++) begin
            d = dot3(plane_regs[p], axes[i]);
            mag = (d < 0) ? -d : d;
            q = (mag + ONE_AXIS - 1) >>> AXIS_FRAC;
            extent += component(64'(b.halves), i) * q;
         end
         center_dist = dot3(64'(b.center), plane_regs[p])
                     + component(plane_regs[p], 3) * ONE_AXIS;
         if (center_dist - extent > 0) outside = 1'b1;
         else if (center_dist + extent >= 0) touching = 1'b1;
      end
      if (outside) return CLASS_OUTSIDE;
      if (touching) return CLASS_INTERSECTING;
      return CLASS_INSIDE;
   endfunction

   function automatic logic [63:0] pack_comps(input longint c0, c1, c2, c3);
      logic [63:0] mask;
      mask = (64'd1 << CW) - 64'd1;
      return (64'(c0) & mask) | ((64'(c1) & mask) << CW) |
             ((64'(c2) & mask) << (2 * CW)) | ((64'(c3) & mask) << (3 * CW));
   endfunction

   function automatic logic [FIELD_WIDTH-1:0] pack_field(input longint c0, c1, c2);
      return FIELD_WIDTH'(pack_comps(c0, c1, c2, 0));
   endfunction

   function automatic longint signed_rand(input longint span);
      return longint'($urandom_range(0, int'(2 * span))) - span;
   endfunction

   function automatic void pick_dir(output longint x, y, z);
      longint r, t;
      r = ONE_AXIS * 7071 / 10000;
      t = ONE_AXIS * 5774 / 10000;
      case ($urandom_range(0, 6))
         0: begin x = ONE_AXIS; y = 0; z = 0; end
         1: begin x = 0; y = ONE_AXIS; z = 0; end
         2: begin x = 0; y = 0; z = ONE_AXIS; end
         3: begin x = r; y = r; z = 0; end
         4: begin x = r; y = 0; z = -r; end
         5: begin x = 0; y = r; z = r; end
         default: begin x = t; y = -t; z = t; end
      endcase
      if ($urandom_range(0, 1)) begin
         x = -x;
         y = -y;
         z = -z;
      end
   endfunction

   function automatic box_type aligned_box(input longint cx, input longint h);
      box_type b;
      b.center = pack_field(cx, 0, 0);
      b.axis_a = pack_field(ONE_AXIS, 0, 0);
      b.axis_b = pack_field(0, ONE_AXIS, 0);
      b.axis_c = pack_field(0, 0, ONE_AXIS);
      b.halves = pack_field(h, h, h);
      return b;
   endfunction

   function automatic box_type uniform_box(input longint c);
      box_type b;
      b.center = pack_field(c, c, c);
      b.axis_a = b.center;
      b.axis_b = b.center;
      b.axis_c = b.center;
      b.halves = b.center;
      return b;
   endfunction

   function automatic box_type random_box(input int well_formed_pct);
      box_type b;
      longint x, y, z, h0, h1, h2;
      if ($urandom_range(0, 99) >= well_formed_pct) begin
         b.center = FIELD_WIDTH'({$urandom, $urandom});
         b.axis_a = FIELD_WIDTH'({$urandom, $urandom});
         b.axis_b = FIELD_WIDTH'({$urandom, $urandom});
         b.axis_c = FIELD_WIDTH'({$urandom, $urandom});
         b.halves = FIELD_WIDTH'({$urandom, $urandom});
         return b;
      end
      b.center = pack_field(signed_rand(48 * ONE_POS), signed_rand(48 * ONE_POS),
                            signed_rand(48 * ONE_POS));
      pick_dir(x, y, z);
      b.axis_a = pack_field(x, y, z);
      pick_dir(x, y, z);
      b.axis_b = pack_field(x, y, z);
      pick_dir(x, y, z);
      b.axis_c = pack_field(x, y, z);
      h0 = longint'($urandom_range(0, int'(16 * ONE_POS)));
      h1 = longint'($urandom_range(0, int'(16 * ONE_POS)));
      h2 = longint'($urandom_range(0, int'(16 * ONE_POS)));
      if ($urandom_range(0, 9) == 0) h1 = -h1;
      b.halves = pack_field(h0, h1, h2);
      return b;
   endfunction

   task automatic report_error(input string what);
      error_count++;
      if (error_count <= 10) $display("error at cycle %0d: %s", cycle_count, what);
   endtask

   task automatic write_plane(input int idx, input logic [PLANE_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx[CSR_INDEX_WIDTH-1:0];
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_PLANES) plane_regs[idx] = val;
   endtask

   // opposite plane pairs, each at distance size from the origin
   task automatic load_frustum(input longint size, input bit aligned);
      longint x, y, z;
      for (int k = 0; k < 3; k++) begin
         if (aligned) begin
            x = (k == 0) ? ONE_AXIS : 0;
            y = (k == 1) ? ONE_AXIS : 0;
            z = (k == 2) ? ONE_AXIS : 0;
         end else begin
            pick_dir(x, y, z);
         end
         write_plane(2 * k, pack_comps(x, y, z, -size));
         write_plane(2 * k + 1, pack_comps(-x, -y, -z, -size));
      end
   endtask

   task automatic load_uniform_planes(input longint c);
      for (int p = 0; p < NUM_PLANES; p++) write_plane(p, pack_comps(c, c, c, c));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_class.size() != 0) @(posedge clock);
   endtask

   task automatic sender_gap();
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
   endtask

   task automatic send_box(input box_type b);
      req_valid <= 1'b1;
      req_box_center <= b.center;
      req_box_axis_a <= b.axis_a;
      req_box_axis_b <= b.axis_b;
      req_box_axis_c <= b.axis_c;
      req_box_half_sizes <= b.halves;
      do @(posedge clock); while (req_stall);
      expected_class.push_back(classify_box(b));
   endtask

   task automatic run_random_phase(input int idle, input int stall, input bit pause_midway);
      idle_pct = idle;
      stall_pct = stall;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         if (pause_midway && k == PHASE_ITEMS / 2) wait_idle();
         sender_gap();
         send_box(random_box(80));
      end
      wait_idle();
   endtask

   task automatic test_reset_planes();
      send_box(uniform_box(0));
      send_box(uniform_box(-1));
      wait_idle();
   endtask

   task automatic test_cube_directed();
      box_type b;
      longint r;
      r = ONE_AXIS * 7071 / 10000;
      load_frustum(10 * ONE_POS, 1'b1);
      // out of range indexes must leave the planes alone
      write_plane(NUM_PLANES, '1);
      write_plane(NUM_PLANES + 1, '1);
      csr_valid <= 1'b0;
      send_box(aligned_box(0, ONE_POS));
      send_box(aligned_box(20 * ONE_POS, ONE_POS));
      send_box(aligned_box(-20 * ONE_POS, ONE_POS));
      send_box(aligned_box(9 * ONE_POS + ONE_POS / 2, ONE_POS));
      send_box(aligned_box(9 * ONE_POS, ONE_POS));
      send_box(aligned_box(11 * ONE_POS, ONE_POS));
      send_box(aligned_box(10 * ONE_POS + ONE_POS / 2, -ONE_POS));
      b = aligned_box(8 * ONE_POS, 2 * ONE_POS);
      b.axis_a = pack_field(r, r, 0);
      b.axis_b = pack_field(r, -r, 0);
      send_box(b);
      b = aligned_box(0, ONE_POS);
      b.axis_a = pack_field(COMP_MAX, COMP_MAX, COMP_MAX);
      b.axis_b = b.axis_a;
      b.axis_c = pack_field(COMP_MIN, COMP_MIN, COMP_MIN);
      send_box(b);
      send_box(uniform_box(-1));
      send_box(uniform_box(0));
      send_box(uniform_box(COMP_MIN));
      send_box(uniform_box(COMP_MAX));
      wait_idle();
   endtask

   task automatic test_extreme_planes();
      load_uniform_planes(-1);
      send_box(uniform_box(0));
      send_box(uniform_box(COMP_MAX));
      wait_idle();
      load_uniform_planes(COMP_MIN);
      send_box(uniform_box(COMP_MAX));
      send_box(uniform_box(COMP_MIN));
      wait_idle();
      load_uniform_planes(COMP_MAX);
      send_box(uniform_box(COMP_MIN));
      send_box(uniform_box(COMP_MAX));
      wait_idle();
   endtask

   task automatic test_random_steady();
      load_frustum(longint'($urandom_range(1, 40)) * ONE_POS, 1'b1);
      csr_valid <= 1'b0;
      run_random_phase(0, 0, 1'b0);
   endtask

   task automatic test_random_sender_idle();
      load_frustum(longint'($urandom_range(1, 40)) * ONE_POS, 1'b0);
      csr_valid <= 1'b0;
      run_random_phase(71, 0, 1'b1);
   endtask

   task automatic test_random_receiver_stall();
      load_frustum(longint'($urandom_range(1, 40)) * ONE_POS, 1'b0);
      csr_valid <= 1'b0;
      run_random_phase(0, 71, 1'b0);
   endtask

   task automatic test_random_both_idle();
      load_frustum(longint'($urandom_range(1, 40)) * ONE_POS, 1'b0);
      for (int p = 0; p < NUM_PLANES; p++)
         if ($urandom_range(0, 3) == 0) write_plane(p, {$urandom, $urandom});
      csr_valid <= 1'b0;
      run_random_phase(12, 12, 1'b0);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_class.size() == 0) begin
            report_error($sformatf("classification %0d with no word pending",
                                   rsp_classification));
         end else begin
            if (rsp_classification !== expected_class[0])
               report_error($sformatf("classification expected %0d (%s) got %0d",
                                      expected_class[0], expected_class[0].name(),
                                      rsp_classification));
            void'(expected_class.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_planes();
      test_cube_directed();
      test_extreme_planes();
      test_random_steady();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_class.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
